// ===== design/go_to_point_heading_controller_macros.svh =====
// Assertion macros for the go-to-point heading controller
`ifndef GO_TO_POINT_HEADING_CONTROLLER_MACROS_SVH
`define GO_TO_POINT_HEADING_CONTROLLER_MACROS_SVH
`ifndef ASSERT_OFF
`define GTP_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define GTP_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define GTP_ASSERT_IMP(lbl, ante, cons, msg)
`define GTP_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

// ===== design/gtp_pkg.sv =====
// Shared types, constants and tables of the go-to-point heading controller
package gtp_pkg;

  localparam int CORDIC_STEPS = 14;
  localparam int XW    = 32;   // CORDIC x/y width
  localparam int ZW    = 28;   // angle accumulator, 2^-24 rad
  localparam int QW    = 15;   // mix quotient bits
  localparam int RW    = 31;   // divider remainder width
  localparam int MIDQ_DEPTH = 4;
  localparam int MIDQ_AW    = 2;

  localparam logic signed [ZW-1:0] Z_PI    = 28'sd52707179;
  localparam logic [14:0]          ANG_PI  = 15'd25736;
  localparam logic [14:0]          ONE_Q14 = 15'd16384;

  localparam logic [3:0] REG_TARGET_X       = 4'd0;
  localparam logic [3:0] REG_TARGET_Y       = 4'd1;
  localparam logic [3:0] REG_TARGET_HEADING = 4'd2;
  localparam logic [3:0] REG_FORWARD_SPEED  = 4'd3;
  localparam logic [3:0] REG_DIST_TOL       = 4'd4;
  localparam logic [3:0] REG_HEADING_TOL    = 4'd5;
  localparam logic [3:0] REG_ALIGN_WINDOW   = 4'd6;
  localparam logic [3:0] REG_STEER_GAIN     = 4'd7;

  typedef struct packed {
    logic signed [15:0] target_x;
    logic signed [15:0] target_y;
    logic signed [15:0] target_heading;
    logic [14:0]        forward_speed;
    logic [14:0]        distance_tolerance;
    logic [14:0]        heading_tolerance;
    logic [14:0]        align_window;
    logic [15:0]        steer_gain;
  } cfg_t;

  typedef struct packed {
    logic               zero;     // zero vector, bearing 0
    logic               reached;  // inside position band
    logic               arrive;   // position and heading in band
    logic signed [16:0] e_tgt;    // heading error to final heading
    logic signed [15:0] h;
  } side_t;

  typedef struct packed {
    logic signed [XW-1:0] x;
    logic signed [XW-1:0] y;
    logic signed [ZW-1:0] z;
    side_t                side;
  } mid_t;

  typedef struct packed {
    logic [RW-1:0] rem_l;
    logic [RW-1:0] rem_r;
    logic [QW-1:0] q_l;
    logic [QW-1:0] q_r;
    logic          neg_l;
    logic          neg_r;
    logic          kill;
    logic          arrive;
    logic [15:0]   den;
  } div_t;

  typedef struct packed {
    logic signed [15:0] left;
    logic signed [15:0] right;
    logic               arrived;
  } res_t;

  function automatic logic signed [ZW-1:0] atan_tab(input int unsigned i);
    logic signed [ZW-1:0] v;
    case (i)
      0:  v = 28'sd13176795;
      1:  v = 28'sd7778716;
      2:  v = 28'sd4110060;
      3:  v = 28'sd2086331;
      4:  v = 28'sd1047214;
      5:  v = 28'sd524117;
      6:  v = 28'sd262123;
      7:  v = 28'sd131069;
      8:  v = 28'sd65536;
      9:  v = 28'sd32768;
      10: v = 28'sd16384;
      11: v = 28'sd8192;
      12: v = 28'sd4096;
      13: v = 28'sd2048;
      14: v = 28'sd1024;
      15: v = 28'sd512;
      16: v = 28'sd256;
      17: v = 28'sd128;
      18: v = 28'sd64;
      19: v = 28'sd32;
      20: v = 28'sd16;
      21: v = 28'sd8;
      22: v = 28'sd4;
      23: v = 28'sd2;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

// ===== design/gtp_front.sv =====
// Front end: takes a pose, classifies it and prepares the CORDIC start vector
module gtp_front import gtp_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  cfg_t               cfg,
  input  logic               push,
  output logic               full,
  input  logic signed [15:0] pos_x,
  input  logic signed [15:0] pos_y,
  input  logic signed [15:0] heading,
  output logic               mid_valid,
  output mid_t               mid_item,
  input  logic               mid_ready
);

  logic               fv;
  mid_t               item;
  mid_t               item_next;
  logic               advance;
  logic signed [16:0] dx, dy, e_tgt;
  logic [16:0]        adx, ady, ae;
  logic               reached;
  logic signed [XW-1:0] x0, y0;

  assign advance = !fv || mid_ready;
  assign full    = !advance;

  always_comb begin
    dx    = $signed({cfg.target_x[15], cfg.target_x}) - $signed({pos_x[15], pos_x});
    dy    = $signed({cfg.target_y[15], cfg.target_y}) - $signed({pos_y[15], pos_y});
    e_tgt = $signed({heading[15], heading})
            - $signed({cfg.target_heading[15], cfg.target_heading});
    adx   = dx[16] ? 17'(-dx) : 17'(dx);
    ady   = dy[16] ? 17'(-dy) : 17'(dy);
    ae    = e_tgt[16] ? 17'(-e_tgt) : 17'(e_tgt);
    reached = (adx <= {2'b00, cfg.distance_tolerance})
              && (ady <= {2'b00, cfg.distance_tolerance});
    x0 = {{3{dy[16]}}, dy, 12'h000};
    y0 = {{3{dx[16]}}, dx, 12'h000};

    item_next.side.zero    = (dx == 17'sd0) && (dy == 17'sd0);
    item_next.side.reached = reached;
    item_next.side.arrive  = reached && (ae <= {2'b00, cfg.heading_tolerance});
    item_next.side.e_tgt   = e_tgt;
    item_next.side.h       = heading;
    // rotate into the right half-plane
    if (x0 < 0) begin
      item_next.x = -x0;
      item_next.y = -y0;
      item_next.z = (y0 >= 0) ? Z_PI : -Z_PI;
    end else begin
      item_next.x = x0;
      item_next.y = y0;
      item_next.z = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fv <= 1'b0;
    end else if (advance) begin
      fv <= push;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && push) begin
      item <= item_next;
    end
  end

  assign mid_valid = fv;
  assign mid_item  = item;

endmodule

// ===== design/gtp_midq.sv =====
// Short queue between front end and back end
module gtp_midq import gtp_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  mid_t in_item,
  output logic out_valid,
  input  logic out_ready,
  output mid_t out_item
);

  mid_t               mem [MIDQ_DEPTH];
  logic [MIDQ_AW-1:0] wptr, rptr;
  logic [MIDQ_AW:0]   count;
  logic               wr, rd;

  assign in_ready  = (count != (MIDQ_AW+1)'(MIDQ_DEPTH));
  assign out_valid = (count != '0);
  assign wr        = in_valid && in_ready;
  assign rd        = out_valid && out_ready;
  assign out_item  = mem[rptr];

  always_ff @(posedge clk) begin
    if (wr) begin
      mem[wptr] <= in_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (wr) wptr <= wptr + 1'b1;
      if (rd) rptr <= rptr + 1'b1;
      count <= count + (MIDQ_AW+1)'(wr) - (MIDQ_AW+1)'(rd);
    end
  end

endmodule

// ===== design/gtp_back.sv =====
// Back end: CORDIC bearing, steering, arcade mix with pipelined divider, result queue
module gtp_back import gtp_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  cfg_t               cfg,
  input  logic               in_valid,
  output logic               in_ready,
  input  mid_t               in_item,
  output logic               empty,
  input  logic               pop,
  output logic signed [15:0] left_drive,
  output logic signed [15:0] right_drive,
  output logic               arrived
);

  localparam int N = CORDIC_STEPS;

  logic en;

  // CORDIC chain
  logic [N:0]           cv;
  logic signed [XW-1:0] cx [N+1];
  logic signed [XW-1:0] cy [N+1];
  logic signed [ZW-1:0] cz [N+1];
  side_t                cs [N+1];

  always_ff @(posedge clk) begin
    if (rst) cv[0] <= 1'b0;
    else if (en) cv[0] <= in_valid;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cx[0] <= in_item.x;
      cy[0] <= in_item.y;
      cz[0] <= in_item.z;
      cs[0] <= in_item.side;
    end
  end

  for (genvar k = 0; k < N; k++) begin : g_cordic
    logic signed [XW-1:0] xs, ys;
    assign xs = cx[k] >>> k;
    assign ys = cy[k] >>> k;

    always_ff @(posedge clk) begin
      if (rst) cv[k+1] <= 1'b0;
      else if (en) cv[k+1] <= cv[k];
    end

    always_ff @(posedge clk) begin
      if (en) begin
        cs[k+1] <= cs[k];
        if (cy[k] > 0) begin
          cx[k+1] <= cx[k] + ys;
          cy[k+1] <= cy[k] - xs;
          cz[k+1] <= cz[k] + atan_tab(k);
        end else begin
          cx[k+1] <= cx[k] - ys;
          cy[k+1] <= cy[k] + xs;
          cz[k+1] <= cz[k] - atan_tab(k);
        end
      end
    end
  end

  // Stage A: bearing rounding, angle error, forward gate
  logic [ZW-1:0]      za;
  logic [16:0]        zm;
  logic [14:0]        zc;
  logic signed [15:0] brg;
  logic signed [16:0] e_a_next;
  logic [16:0]        ae_a;
  logic [14:0]        fs;
  logic               va;
  logic signed [16:0] ea;
  logic [14:0]        fa;
  logic               arr_a;

  always_comb begin
    za  = cz[N][ZW-1] ? ZW'(-cz[N]) : ZW'(cz[N]);
    zm  = 17'((za + ZW'(1024)) >> 11);
    zc  = (zm > {2'b00, ANG_PI}) ? ANG_PI : zm[14:0];
    if (cs[N].zero) brg = '0;
    else if (cz[N][ZW-1]) brg = -$signed({1'b0, zc});
    else brg = $signed({1'b0, zc});
    e_a_next = cs[N].reached ? cs[N].e_tgt
             : $signed({cs[N].h[15], cs[N].h}) - $signed({brg[15], brg});
    ae_a = e_a_next[16] ? 17'(-e_a_next) : 17'(e_a_next);
    fs   = (cfg.forward_speed > ONE_Q14) ? ONE_Q14 : cfg.forward_speed;
  end

  always_ff @(posedge clk) begin
    if (rst) va <= 1'b0;
    else if (en) va <= cv[N];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ea    <= e_a_next;
      fa    <= (!cs[N].reached && (ae_a <= {2'b00, cfg.align_window})) ? fs : '0;
      arr_a <= cs[N].arrive;
    end
  end

  // Stage B: gain and forward square
  logic               vb;
  logic signed [33:0] pb;
  logic [29:0]        ffb;
  logic [14:0]        fb;
  logic               arr_b;

  always_ff @(posedge clk) begin
    if (rst) vb <= 1'b0;
    else if (en) vb <= va;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pb    <= ea * $signed({1'b0, cfg.steer_gain});
      ffb   <= fa * fa;
      fb    <= fa;
      arr_b <= arr_a;
    end
  end

  // Stage C: steer rounding and saturation
  logic [33:0] apb;
  logic [20:0] mr;
  logic [14:0] mrc;
  logic        vc;
  logic [14:0] arc;
  logic        negc;
  logic [29:0] ffc;
  logic [14:0] fc;
  logic        arr_c;

  always_comb begin
    apb = pb[33] ? 34'(-pb) : 34'(pb);
    mr  = 21'((apb + 34'd4096) >> 13);
    mrc = (mr > {6'd0, ONE_Q14}) ? ONE_Q14 : mr[14:0];
  end

  always_ff @(posedge clk) begin
    if (rst) vc <= 1'b0;
    else if (en) vc <= vb;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      arc   <= mrc;
      negc  <= pb[33];
      ffc   <= ffb;
      fc    <= fb;
      arr_c <= arr_b;
    end
  end

  // Stage D: steer square and mix denominator
  logic        vd;
  logic [29:0] rrd;
  logic [29:0] ffd;
  logic        negd;
  logic [15:0] dend;
  logic        arr_d;

  always_ff @(posedge clk) begin
    if (rst) vd <= 1'b0;
    else if (en) vd <= vc;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rrd   <= arc * arc;
      ffd   <= ffc;
      negd  <= negc;
      dend  <= {1'b0, fc} + {1'b0, arc};
      arr_d <= arr_c;
    end
  end

  // Stage E: signed numerators, magnitudes plus half divisor
  logic signed [31:0] rrs, nl, nr;
  logic [RW-1:0]      al, ar;
  div_t               ds [QW+1];
  logic [QW:0]        dv;

  always_comb begin
    rrs = negd ? -$signed({2'b00, rrd}) : $signed({2'b00, rrd});
    nl  = $signed({2'b00, ffd}) + rrs;
    nr  = $signed({2'b00, ffd}) - rrs;
    al  = nl[31] ? RW'(-nl) : nl[RW-1:0];
    ar  = nr[31] ? RW'(-nr) : nr[RW-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) dv[0] <= 1'b0;
    else if (en) dv[0] <= vd;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ds[0].rem_l  <= al + RW'(dend[15:1]);
      ds[0].rem_r  <= ar + RW'(dend[15:1]);
      ds[0].q_l    <= '0;
      ds[0].q_r    <= '0;
      ds[0].neg_l  <= nl[31];
      ds[0].neg_r  <= nr[31];
      ds[0].kill   <= arr_d || (dend == '0);
      ds[0].arrive <= arr_d;
      ds[0].den    <= dend;
    end
  end

  // Restoring divider, one quotient bit per stage, MSB first
  for (genvar j = 0; j < QW; j++) begin : g_div
    localparam int SH = QW - 1 - j;
    logic [RW-1:0] trial;
    logic          bl, br;
    div_t          dn;
    assign trial = RW'(ds[j].den) << SH;
    assign bl    = ds[j].rem_l >= trial;
    assign br    = ds[j].rem_r >= trial;

    always_comb begin
      dn       = ds[j];
      dn.rem_l = bl ? ds[j].rem_l - trial : ds[j].rem_l;
      dn.rem_r = br ? ds[j].rem_r - trial : ds[j].rem_r;
      dn.q_l   = ds[j].q_l | (bl ? QW'(1) << SH : '0);
      dn.q_r   = ds[j].q_r | (br ? QW'(1) << SH : '0);
    end

    always_ff @(posedge clk) begin
      if (rst) dv[j+1] <= 1'b0;
      else if (en) dv[j+1] <= dv[j];
    end

    always_ff @(posedge clk) begin
      if (en) begin
        ds[j+1] <= dn;
      end
    end
  end

  // Result queue, two beats
  res_t       oq [2];
  logic       owp, orp;
  logic [1:0] ocnt;
  logic       ofull, opush, opop;
  res_t       res;

  always_comb begin
    res.arrived = ds[QW].arrive;
    if (ds[QW].kill) begin
      res.left  = '0;
      res.right = '0;
    end else begin
      res.left  = ds[QW].neg_l ? -$signed({1'b0, ds[QW].q_l}) : $signed({1'b0, ds[QW].q_l});
      res.right = ds[QW].neg_r ? -$signed({1'b0, ds[QW].q_r}) : $signed({1'b0, ds[QW].q_r});
    end
  end

  assign ofull    = (ocnt == 2'd2);
  assign empty    = (ocnt == 2'd0);
  assign opush    = dv[QW] && !ofull;
  assign opop     = pop && !empty;
  assign en       = !(dv[QW] && ofull);
  assign in_ready = en;

  always_ff @(posedge clk) begin
    if (opush) begin
      oq[owp] <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      owp  <= 1'b0;
      orp  <= 1'b0;
      ocnt <= '0;
    end else begin
      if (opush) owp <= !owp;
      if (opop) orp <= !orp;
      ocnt <= ocnt + 2'(opush) - 2'(opop);
    end
  end

  assign left_drive  = oq[orp].left;
  assign right_drive = oq[orp].right;
  assign arrived     = oq[orp].arrived;

endmodule

// ===== design/go_to_point_heading_controller.sv =====
// Top level of the go-to-point heading controller: config registers and block wiring
// Differential-drive go-to-point controller. Each beat on the input queue is a
// measured pose (pos_x, pos_y in 1/1024 m, heading in 2^-13 rad); each beat on
// the result queue is left/right drive in Q1.14 plus an arrived flag, one per
// pose, in order. One pose is taken per clock cycle when the result side keeps
// up; the path from the accepting edge to the result showing runs through the
// front register, queue write, CORDIC input stage, 14 CORDIC stages, five
// arithmetic stages, 15 divider stages and the result queue.
// Configuration goes
// through cfg_valid/cfg_ready with cfg_index 0..7 (target x/y/heading, forward
// speed, distance band, heading band, align window, steer gain); other indices
// are ignored. Write configuration only while the block is idle.
`include "go_to_point_heading_controller_macros.svh"

module go_to_point_heading_controller import gtp_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  // pose input
  input  logic               push,
  output logic               full,
  input  logic signed [15:0] pos_x,
  input  logic signed [15:0] pos_y,
  input  logic signed [15:0] heading,
  // drive results
  output logic               empty,
  input  logic               pop,
  output logic signed [15:0] left_drive,
  output logic signed [15:0] right_drive,
  output logic               arrived,
  // configuration writes
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [3:0]         cfg_index,
  input  logic [15:0]        cfg_data
);

  cfg_t cfg;
  logic mid_in_valid, mid_in_ready;
  mid_t mid_in_item;
  logic mid_out_valid, mid_out_ready;
  mid_t mid_out_item;

  // writes always taken; index beyond the map is dropped
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.target_x           <= '0;
      cfg.target_y           <= '0;
      cfg.target_heading     <= '0;
      cfg.forward_speed      <= 15'd8192;
      cfg.distance_tolerance <= 15'd10;
      cfg.heading_tolerance  <= 15'd328;
      cfg.align_window       <= 15'd4096;
      cfg.steer_gain         <= 16'd14746;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_TARGET_X:       cfg.target_x           <= cfg_data;
        REG_TARGET_Y:       cfg.target_y           <= cfg_data;
        REG_TARGET_HEADING: cfg.target_heading     <= cfg_data;
        REG_FORWARD_SPEED:  cfg.forward_speed      <= cfg_data[14:0];
        REG_DIST_TOL:       cfg.distance_tolerance <= cfg_data[14:0];
        REG_HEADING_TOL:    cfg.heading_tolerance  <= cfg_data[14:0];
        REG_ALIGN_WINDOW:   cfg.align_window       <= cfg_data[14:0];
        REG_STEER_GAIN:     cfg.steer_gain         <= cfg_data;
        default: ;
      endcase
    end
  end

  // front: band checks, half-plane rotation
  gtp_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .push      (push),
    .full      (full),
    .pos_x     (pos_x),
    .pos_y     (pos_y),
    .heading   (heading),
    .mid_valid (mid_in_valid),
    .mid_item  (mid_in_item),
    .mid_ready (mid_in_ready)
  );

  // decoupling queue
  gtp_midq u_midq (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (mid_in_valid),
    .in_ready  (mid_in_ready),
    .in_item   (mid_in_item),
    .out_valid (mid_out_valid),
    .out_ready (mid_out_ready),
    .out_item  (mid_out_item)
  );

  // back: bearing, steer, mix, result queue
  gtp_back u_back (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .in_valid    (mid_out_valid),
    .in_ready    (mid_out_ready),
    .in_item     (mid_out_item),
    .empty       (empty),
    .pop         (pop),
    .left_drive  (left_drive),
    .right_drive (right_drive),
    .arrived     (arrived)
  );

  // an arrival beat carries zero drive
  `GTP_ASSERT_IMP(a_arrive_zero, !empty && arrived, left_drive == 16'sd0 && right_drive == 16'sd0, "arrival beat with nonzero drive")
  // mix output stays within plus or minus one
  `GTP_ASSERT_IMP(a_drive_range, !empty, left_drive <= 16'sd16384 && left_drive >= -16'sd16384 && right_drive <= 16'sd16384 && right_drive >= -16'sd16384, "drive out of range")
  // gain write lands in the register
  `GTP_ASSERT_NXT(a_gain_write, cfg_valid && cfg_index == REG_STEER_GAIN, cfg.steer_gain == $past(cfg_data), "steer gain write lost")

endmodule

// ===== dv/go_to_point_heading_controller_test.sv =====
// Testbench for the go-to-point heading controller: predicted drive beats checked in order
`timescale 1ns / 100ps

module go_to_point_heading_controller_test;
  import gtp_pkg::*;

  // Angle table in 2^-24 rad, one entry per vectoring step
  localparam longint ATAN_Q24 [24] = '{
    13176795, 7778716, 4110060, 2086331, 1047214, 524117, 262123, 131069,
    65536, 32768, 16384, 8192, 4096, 2048, 1024, 512,
    256, 128, 64, 32, 16, 8, 4, 2};
  localparam int LATENCY = 38;
  localparam int STALL_LIMIT = 5000;

  // Settings the predictor works from; mirror of the block's registers
  typedef struct {
    longint tx, ty, th, fwd, dtol, htol, awin, gain;
  } ctrl_set_t;

  typedef struct {
    logic signed [15:0] left;
    logic signed [15:0] right;
    logic               arr;
  } drive_t;

  // Scoreboard: predicts the drive beat for each accepted pose and checks the outputs
  class drive_board;
    ctrl_set_t cs;
    drive_t    pending[$];
    int        errors;

    function void reset_settings();
      cs.tx = 0; cs.ty = 0; cs.th = 0; cs.fwd = 8192;
      cs.dtol = 10; cs.htol = 328; cs.awin = 4096; cs.gain = 14746;
    endfunction

    function void write_reg(logic [3:0] idx, logic [15:0] d);
      case (idx)
        REG_TARGET_X:       cs.tx = longint'($signed(d));
        REG_TARGET_Y:       cs.ty = longint'($signed(d));
        REG_TARGET_HEADING: cs.th = longint'($signed(d));
        REG_FORWARD_SPEED:  cs.fwd = longint'(d[14:0]);
        REG_DIST_TOL:       cs.dtol = longint'(d[14:0]);
        REG_HEADING_TOL:    cs.htol = longint'(d[14:0]);
        REG_ALIGN_WINDOW:   cs.awin = longint'(d[14:0]);
        REG_STEER_GAIN:     cs.gain = longint'(d);
        default: ;
      endcase
    endfunction

    static function longint mag(longint v);
      return v < 0 ? -v : v;
    endfunction

    // arithmetic shift right, floor
    static function longint sra(longint v, int s);
      return v >>> s;
    endfunction

    static function longint rdiv(longint num, longint den);
      longint m;
      if (den <= 0) return 0;
      m = (mag(num) + den / 2) / den;
      return num < 0 ? -m : m;
    endfunction

    static function longint sat(longint v, longint lim);
      return v > lim ? lim : (v < -lim ? -lim : v);
    endfunction

    static function longint goal_bearing(longint dx, longint dy);
      longint bx, by, acc, nx;
      bx = dy * 4096; by = dx * 4096; acc = 0;
      if (bx == 0 && by == 0) return 0;
      if (bx < 0) begin
        acc = by >= 0 ? 52707179 : -52707179;
        bx = -bx; by = -by;
      end
      for (int i = 0; i < CORDIC_STEPS && i < 24; i++) begin
        if (by > 0) begin
          nx = bx + sra(by, i); by = by - sra(bx, i); acc += ATAN_Q24[i];
        end else begin
          nx = bx - sra(by, i); by = by + sra(bx, i); acc -= ATAN_Q24[i];
        end
        bx = nx;
      end
      return sat(rdiv(acc, 2048), 25736);
    endfunction

    function void note_pose(logic signed [15:0] px, logic signed [15:0] py,
                            logic signed [15:0] hd);
      longint dx, dy, e, f, r, af, ar, den, fs, h;
      drive_t exp_d;
      h = hd; dx = cs.tx - px; dy = cs.ty - py; f = 0;
      fs = cs.fwd > 16384 ? 16384 : cs.fwd;
      exp_d = '{0, 0, 0};
      if (mag(dx) <= cs.dtol && mag(dy) <= cs.dtol) begin
        e = h - cs.th;
        if (mag(e) <= cs.htol) begin
          exp_d.arr = 1;
          pending.push_back(exp_d);
          return;
        end
      end else begin
        e = h - goal_bearing(dx, dy);
        if (mag(e) <= cs.awin) f = fs;
      end
      r = sat(rdiv(e * cs.gain, 8192), 16384);
      af = mag(f); ar = mag(r); den = af + ar;
      if (den != 0) begin
        exp_d.left = 16'(rdiv(f * af + r * ar, den));
        exp_d.right = 16'(rdiv(f * af - r * ar, den));
      end
      pending.push_back(exp_d);
    endfunction

    task check_beat(logic signed [15:0] l, logic signed [15:0] r, logic a);
      drive_t w;
      if (pending.size() == 0) begin
        report("result beat with nothing expected");
        return;
      end
      w = pending.pop_front();
      if (l !== w.left) report($sformatf("left_drive %0d, want %0d", l, w.left));
      if (r !== w.right) report($sformatf("right_drive %0d, want %0d", r, w.right));
      if (a !== w.arr) report($sformatf("arrived %0b, want %0b", a, w.arr));
    endtask

    task report(string msg);
      errors++;
      if (errors <= 40) $display("MISMATCH @%0t: %s", $realtime, msg);
    endtask
  endclass

  logic clk = 0, rst = 1;
  logic push = 0, pop = 0, cfg_valid = 0;
  logic signed [15:0] pos_x = 0, pos_y = 0, heading = 0;
  logic [3:0] cfg_index = 0;
  logic [15:0] cfg_data = 0;
  logic full, empty, arrived, cfg_ready;
  logic signed [15:0] left_drive, right_drive;

  drive_board board = new();
  int  idle_cycles = 0;
  bit  sink_hold = 0;     // receiver held off for the long stretch
  bit  sink_lazy = 1;     // random gaps on the result side

  always begin
    #2 clk = 1;
    #2 clk = 0;
  end

  go_to_point_heading_controller dut (.*);

  // Result side: pop with random gaps, check each accepted beat at the rising edge
  initial begin
    int gap;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      gap = sink_lazy ? ($urandom_range(0, 3) == 0 ? $urandom_range(0, 18) : 0) : 0;
      if (gap != 0 || sink_hold) begin
        pop <= 0;
        repeat (gap) @(negedge clk);
        while (sink_hold) @(negedge clk);
      end
      pop <= 1;
      @(posedge clk);
      while (empty) @(posedge clk);
      board.check_beat(left_drive, right_drive, arrived);
      @(negedge clk);
    end
  end

  // Watchdog on cycles with no accepted beat of any kind
  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("go_to_point_heading_controller test failed");
      $finish;
    end
  end

  // push stays high on return so poses can follow back to back; drain lowers it
  task send_pose(logic signed [15:0] px, logic signed [15:0] py, logic signed [15:0] hd,
                 int gap);
    if (gap != 0) begin
      push <= 0;
      repeat (gap) @(negedge clk);
    end
    push <= 1; pos_x <= px; pos_y <= py; heading <= hd;
    @(posedge clk);
    while (full) @(posedge clk);
    board.note_pose(px, py, hd);
    @(negedge clk);
  endtask

  task write_cfg(logic [3:0] idx, logic [15:0] d);
    cfg_valid <= 1; cfg_index <= idx; cfg_data <= d;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    board.write_reg(idx, d);
    @(negedge clk);
    cfg_valid <= 0;
    @(negedge clk);
  endtask

  // Wait for every expected beat, then let the pipeline settle
  task drain();
    push <= 0;
    while (board.pending.size() != 0) @(negedge clk);
    repeat (LATENCY + 4) @(negedge clk);
  endtask

  function automatic logic signed [15:0] near(longint c, longint spread);
    return 16'(c + $signed($urandom_range(0, 2 * spread)) - spread);
  endfunction

  function automatic logic signed [15:0] any_angle();
    return $urandom_range(0, 7) == 0 ? 16'($urandom) : 16'($urandom_range(0, 51472) - 25736);
  endfunction

  task random_phase(int n, bit near_goal);
    logic signed [15:0] px, py, hd;
    int gap;
    for (int k = 0; k < n; k++) begin
      if (near_goal && $urandom_range(0, 2) != 0) begin
        px = near(board.cs.tx, board.cs.dtol + 3);
        py = near(board.cs.ty, board.cs.dtol + 3);
        hd = $urandom_range(0, 1) ? near(board.cs.th, board.cs.htol + 40) : any_angle();
      end else begin
        px = 16'($urandom); py = 16'($urandom); hd = any_angle();
      end
      gap = $urandom_range(0, 3) == 0 ? $urandom_range(0, 18) : 0;
      if (k > n / 2 && k < n / 2 + 40) gap = 0;   // stretch without idling
      send_pose(px, py, hd, gap);
    end
  endtask

  task random_settings(bit extreme);
    write_cfg(REG_TARGET_X, extreme ? 16'h8000 : 16'($urandom));
    write_cfg(REG_TARGET_Y, extreme ? 16'h7fff : 16'($urandom));
    write_cfg(REG_TARGET_HEADING, extreme ? 16'(-25736) : any_angle());
    write_cfg(REG_FORWARD_SPEED, extreme ? 16'hffff : 16'($urandom_range(0, 20000)));
    write_cfg(REG_DIST_TOL, extreme ? 16'hffff : 16'($urandom_range(0, 600)));
    write_cfg(REG_HEADING_TOL, extreme ? 16'h7fff : 16'($urandom_range(0, 3000)));
    write_cfg(REG_ALIGN_WINDOW, extreme ? 16'h0000 : 16'($urandom_range(0, 25736)));
    write_cfg(REG_STEER_GAIN, extreme ? 16'hffff : 16'($urandom));
  endtask

  initial begin
    board.reset_settings();
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 0;
    @(negedge clk);

    // Directed: reset settings, field extremes, arrival, turn in place, zero vector
    send_pose(0, 0, 0, 0);                 // arrived at goal
    send_pose(5, -5, 329, 0);              // in band, heading just out: turn in place
    send_pose(0, 0, 16'(-25736), 0);
    send_pose(16'h7fff, 16'h7fff, 16'h7fff, 0);
    send_pose(16'h8000, 16'h8000, 16'h8000, 0);
    send_pose(16'h8000, 0, 25736, 0);      // goal behind on x
    send_pose(0, 16'h7fff, 0, 0);          // dy < 0, dx = 0
    send_pose(100, 16'h7fff, 0, 0);        // dy < 0, dx < 0
    send_pose(16'hffff, 16'h0001, 16'hffff, 0);
    send_pose(0, -1000, 0, 0);             // aligned: forward drive
    send_pose(11, 0, 0, 0);                // just outside distance band
    drain();
    write_cfg(REG_STEER_GAIN, 0);          // both mix inputs zero
    write_cfg(REG_ALIGN_WINDOW, 0);
    send_pose(0, 0, 1000, 0);
    send_pose(300, 300, 0, 0);
    drain();
    write_cfg(4'd9, 16'h1234);             // unknown index, ignored
    write_cfg(4'd15, 16'hffff);
    drain();
    random_settings(1);                    // oversized forward speed among others
    send_pose(0, 0, 0, 0);
    send_pose(16'h7fff, 16'h8000, 16'h7fff, 0);
    send_pose(16'h1234, 16'hedcb, 16'h8000, 0);
    drain();

    // Receiver holds off while poses keep coming, so the block fills and stalls
    board.reset_settings();
    for (int i = 0; i < 8; i++) write_cfg(4'(i), i == 3 ? 16'd8192 : i == 4 ? 16'd10 :
      i == 5 ? 16'd328 : i == 6 ? 16'd4096 : i == 7 ? 16'd14746 : 16'd0);
    sink_hold = 1;
    fork
      begin repeat (300) @(negedge clk); sink_hold = 0; end
      random_phase(80, 0);
    join
    drain();   // sender pauses until every beat is back

    for (int ph = 0; ph < 7; ph++) begin
      random_settings(ph == 3);
      sink_lazy = ph != 5;
      random_phase(100, ph % 2 == 0);
      drain();
    end

    if (board.errors == 0 && board.pending.size() == 0)
      $display("go_to_point_heading_controller test passed");
    else
      $display("go_to_point_heading_controller test failed");
    $finish;
  end
endmodule

// ===== filelist.f =====
+incdir+design
design/gtp_pkg.sv
design/gtp_front.sv
design/gtp_midq.sv
design/gtp_back.sv
design/go_to_point_heading_controller.sv
dv/go_to_point_heading_controller_test.sv
